[hw/rtl/station_table_update_defines.svh]
// assertion macros for the station table update block
// no dependencies; included by the top level only
`ifndef STATION_TABLE_UPDATE_DEFINES_SVH
`define STATION_TABLE_UPDATE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define STU_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("station table: same-cycle check failed");

// next-cycle implication, off while reset is high
`define STU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("station table: next-cycle check failed");

`endif

[hw/rtl/stu_pkg.sv]
// shared types and constants for the station table update block
// no dependencies; used by stu_cell and station_table_update
`timescale 1ns / 1ps
`default_nettype none

package stu_pkg;

   localparam int KEY_W   = 48;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;

   localparam logic [TIME_W-1:0]  AGE_LIMIT_RESET = 32'd1800;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 5'd31;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_COUNT = 4'b1000
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] age_limit;
      logic              do_update;
      logic              do_write;
   } cmd_type;

   // running slot choice carried down the chain
   typedef struct packed {
      logic              valid;
      logic              matched;
      logic              have_empty;
      logic              have_old;
      logic [TIME_W-1:0] old_stamp;
   } scan_type;

   // running prune count carried down the chain
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] value;
   } count_type;

endpackage

`default_nettype wire

[hw/rtl/stu_cell.sv]
// one table entry: key, stamp, and its stage of the scan and count chains
// depends on stu_pkg
`timescale 1ns / 1ps
`default_nettype none

module stu_cell
   import stu_pkg::*;
#(
   parameter int IW = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [IW-1:0]   cell_idx,
   input  wire cmd_type         cmd,
   input  wire logic [IW-1:0]   slot,
   input  wire scan_type        scan_in,
   input  wire logic [IW-1:0]   scan_idx_in,
   output scan_type             scan_out,
   output logic [IW-1:0]        scan_idx_out,
   input  wire count_type       count_in,
   output count_type            count_out
);

   logic [KEY_W-1:0]  key_high_ff;
   logic [KEY_W-1:0]  key_low_ff;
   logic [TIME_W-1:0] stamp_ff;
   logic              prune_ff;
   scan_type          scan_ff;
   scan_type          scan_in_next;
   logic [IW-1:0]     scan_idx_ff;
   logic [IW-1:0]     scan_idx_in_next;
   count_type         count_ff;
   count_type         count_in_next;

   logic              empty;
   logic              hit;
   logic              stale;
   logic [TIME_W-1:0] age;
   logic [COUNT_W:0]  sum;

   assign empty = (key_high_ff == '0) && (key_low_ff == '0);
   assign hit   = (key_high_ff == cmd.key_high) && (key_low_ff == cmd.key_low);
   assign age   = cmd.now_time - stamp_ff;
   assign stale = (stamp_ff != '0) && (age > cmd.age_limit);

   // match beats first empty beats oldest stamp; earlier cells win ties
   always_comb begin
      scan_in_next     = scan_in;
      scan_idx_in_next = scan_idx_in;
      if (!scan_in.matched) begin
         if (hit) begin
            scan_in_next.matched = 1'b1;
            scan_idx_in_next     = cell_idx;
         end else if (!scan_in.have_empty) begin
            if (empty) begin
               scan_in_next.have_empty = 1'b1;
               scan_idx_in_next        = cell_idx;
            end else if (stamp_ff != '0 &&
                         (!scan_in.have_old || stamp_ff < scan_in.old_stamp)) begin
               scan_in_next.have_old  = 1'b1;
               scan_in_next.old_stamp = stamp_ff;
               scan_idx_in_next       = cell_idx;
            end
         end
      end
   end

   assign sum = {1'b0, count_in.value} + {{COUNT_W{1'b0}}, prune_ff};

   always_comb begin
      count_in_next.valid = count_in.valid;
      if (sum > {1'b0, COUNT_MAX}) begin
         count_in_next.value = COUNT_MAX;
      end else begin
         count_in_next.value = sum[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         stamp_ff    <= '0;
         prune_ff    <= 1'b0;
         scan_ff     <= '0;
         count_ff    <= '0;
      end else begin
         scan_ff  <= scan_in_next;
         count_ff <= count_in_next;
         if (cmd.do_update) begin
            // a freshly written entry has age zero and is not pruned in this update
            if (cmd.do_write && slot == cell_idx) begin
               key_high_ff <= cmd.key_high;
               key_low_ff  <= cmd.key_low;
               stamp_ff    <= cmd.now_time;
               prune_ff    <= 1'b0;
            end else if (stale) begin
               key_high_ff <= '0;
               key_low_ff  <= '0;
               stamp_ff    <= '0;
               prune_ff    <= 1'b1;
            end else begin
               prune_ff    <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in_next;
   end

   assign scan_out     = scan_ff;
   assign scan_idx_out = scan_idx_ff;
   assign count_out    = count_ff;

endmodule

`default_nettype wire

[hw/rtl/station_table_update.sv]
// station table update: controller and the chain of table cells
// depends on stu_pkg, stu_cell and station_table_update_defines.svh
//
// usage:
//  - request channel: req_callsign_high, req_callsign_low, req_now_time are taken
//    at a clock edge where start is high and busy is low; busy then stays high
//    until the cycle in which the result is shown
//  - result channel: rsp_slot, rsp_new_station, rsp_inserted, rsp_pruned_count
//    are valid for exactly one cycle while rsp_valid is high; the receiver
//    cannot stall, so the result is never held
//  - csr_write_enable / csr_write_data write age_limit (1800 after reset);
//    write only while busy is low
//  - each item makes two passes down the row of ENTRIES cells, one cell per
//    cycle: a scan pass that picks the slot, a write and prune step in all
//    cells at once, then a pass that sums the pruned entries
//  - a new item is taken only while busy is low, so not before the last item is through
//  - reset clears the whole table (all keys and stamps zero) and the control
//    state, and sets age_limit to 1800; no clearing pass is needed afterwards
`timescale 1ns / 1ps
`default_nettype none

`include "station_table_update_defines.svh"

module station_table_update
   import stu_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [KEY_W-1:0]    req_callsign_high,
   input  wire logic [KEY_W-1:0]    req_callsign_low,
   input  wire logic [TIME_W-1:0]   req_now_time,
   output logic                     rsp_valid,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic                     rsp_new_station,
   output logic                     rsp_inserted,
   output logic [COUNT_W-1:0]       rsp_pruned_count,
   input  wire logic                csr_write_enable,
   input  wire logic [TIME_W-1:0]   csr_write_data
);

   localparam int IW = $clog2(ENTRIES);

   state_type         state_ff;
   state_type         state_in;
   logic [TIME_W-1:0] age_limit_ff;
   logic [KEY_W-1:0]  key_high_ff;
   logic [KEY_W-1:0]  key_low_ff;
   logic [TIME_W-1:0] now_ff;
   logic [IW-1:0]     slot_ff;
   logic              matched_ff;
   logic              scan_launch_ff;
   logic              count_launch_ff;

   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_new_station_ff;
   logic               rsp_inserted_ff;
   logic [COUNT_W-1:0] rsp_pruned_count_ff;

   logic                 key_present;
   logic [IW+SLOT_W-1:0] slot_wide;
   cmd_type              cmd;
   scan_type             scan_chain [ENTRIES+1];
   logic [IW-1:0]        idx_chain  [ENTRIES+1];
   count_type            count_chain[ENTRIES+1];

   assign key_present = (key_high_ff != '0) || (key_low_ff != '0);
   assign slot_wide   = {{SLOT_W{1'b0}}, slot_ff};

   assign cmd.key_high  = key_high_ff;
   assign cmd.key_low   = key_low_ff;
   assign cmd.now_time  = now_ff;
   assign cmd.age_limit = age_limit_ff;
   assign cmd.do_update = (state_ff == ST_WRITE);
   assign cmd.do_write  = (state_ff == ST_WRITE) && key_present;

   // wave heads: an empty choice enters cell 0 with a zero count
   assign scan_chain[0].valid      = scan_launch_ff;
   assign scan_chain[0].matched    = 1'b0;
   assign scan_chain[0].have_empty = 1'b0;
   assign scan_chain[0].have_old   = 1'b0;
   assign scan_chain[0].old_stamp  = '0;
   assign idx_chain[0]             = '0;
   assign count_chain[0].valid     = count_launch_ff;
   assign count_chain[0].value     = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      stu_cell #(
         .IW(IW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IW'(i)),
         .cmd         (cmd),
         .slot        (slot_ff),
         .scan_in     (scan_chain[i]),
         .scan_idx_in (idx_chain[i]),
         .scan_out    (scan_chain[i+1]),
         .scan_idx_out(idx_chain[i+1]),
         .count_in    (count_chain[i]),
         .count_out   (count_chain[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_chain[ENTRIES].valid) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (count_chain[ENTRIES].valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         age_limit_ff    <= AGE_LIMIT_RESET;
         scan_launch_ff  <= 1'b0;
         count_launch_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         scan_launch_ff  <= (state_ff == ST_IDLE) && start;
         count_launch_ff <= (state_ff == ST_WRITE);
         rsp_valid_ff    <= (state_ff == ST_COUNT) && count_chain[ENTRIES].valid;
         if (csr_write_enable) begin
            age_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         key_high_ff <= req_callsign_high;
         key_low_ff  <= req_callsign_low;
         now_ff      <= req_now_time;
      end
      if (state_ff == ST_SCAN && scan_chain[ENTRIES].valid) begin
         slot_ff    <= idx_chain[ENTRIES];
         matched_ff <= scan_chain[ENTRIES].matched;
      end
      if (state_ff == ST_COUNT && count_chain[ENTRIES].valid) begin
         rsp_slot_ff         <= key_present ? slot_wide[SLOT_W-1:0] : '0;
         rsp_new_station_ff  <= key_present && !matched_ff;
         rsp_inserted_ff     <= key_present;
         rsp_pruned_count_ff <= count_chain[ENTRIES].value;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_new_station  = rsp_new_station_ff;
   assign rsp_inserted     = rsp_inserted_ff;
   assign rsp_pruned_count = rsp_pruned_count_ff;

   `STU_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy)
   `STU_ASSERT_NEXT(a_one_result_per_item, clock, reset, rsp_valid, !rsp_valid)
   `STU_ASSERT_IMPLIES(a_new_needs_insert, clock, reset, rsp_valid && rsp_new_station, rsp_inserted)
   `STU_ASSERT_IMPLIES(a_scan_ends_in_scan, clock, reset, scan_chain[ENTRIES].valid, state_ff == ST_SCAN)

endmodule

`default_nettype wire
